// File: rtl/core/bmg_pkg.sv
// shared constants, tables and pipeline word types of the box-muller gaussian source
package bmg_pkg;

    localparam int UNIFORM_BITS = 32;
    localparam int SAMPLE_BITS  = 32;
    localparam int TDATA_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int ROUND_SH     = 65 - SAMPLE_BITS;

    localparam logic [31:0] UMASK      = 32'((64'd1 << UNIFORM_BITS) - 64'd1);
    localparam logic [31:0] LN2_Q32    = 32'hB172_17F8;
    localparam logic [33:0] PI_Q32     = 34'h3_243F_6A89;
    localparam logic [31:0] PI_QUARTER = 32'(PI_Q32 >> 2);
    localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;

    localparam logic [SAMPLE_BITS-1:0] SAT_POS = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_NEG = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    localparam logic [7:0] SIN_DEN [6] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
    localparam logic [7:0] COS_DEN [6] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};

    localparam logic [31:0] SIN_RECIP [6] = '{
        32'((64'd1 << 32) / 64'd6),   32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd156)
    };
    localparam logic [31:0] COS_RECIP [6] = '{
        32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 32) / 64'd12),
        32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd56),
        32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd132)
    };

    typedef struct packed {
        logic        valid;
        logic        last;
        logic [31:0] angle;
        logic [31:0] z;
        logic [4:0]  lz;
        logic [29:0] f;
    } front_t;

    typedef struct packed {
        logic        valid;
        logic        last;
        logic [31:0] angle;
        logic [37:0] t1;
        logic [61:0] t2;
    } sq1_t;

    typedef struct packed {
        logic        valid;
        logic        last;
        logic [31:0] angle;
        logic [63:0] v;
        logic [63:0] res;
    } root_t;

    typedef struct packed {
        logic        valid;
        logic        last;
        logic [2:0]  oct;
        logic [31:0] amp;
        logic [31:0] xr;
        logic [31:0] x2;
        logic [32:0] hs;
        logic [32:0] hc;
    } trig_t;

    typedef struct packed {
        logic        valid;
        logic        last;
        logic [2:0]  oct;
        logic [31:0] amp;
        logic [32:0] s;
        logic [32:0] c;
    } fin_t;

    typedef struct packed {
        logic        valid;
        logic        last;
        logic        neg_s;
        logic        neg_c;
        logic [63:0] ps;
        logic [63:0] pc;
    } prod_t;

    typedef struct packed {
        logic                   valid;
        logic                   last;
        logic [SAMPLE_BITS-1:0] sine;
        logic [SAMPLE_BITS-1:0] cosine;
    } res_t;

endpackage

// File: rtl/core/bmg_norm_cell.sv
// one step of the leading-zero normalising shift
module bmg_norm_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [2:0]      level,
    input  bmg_pkg::front_t din,
    output bmg_pkg::front_t dout
);
    import bmg_pkg::*;

    front_t     w_reg;
    front_t     w_next;
    logic [5:0] amount;

    always_comb
    begin
        amount = 6'd1 << level;
        w_next = din;
        if ((din.z >> (6'd32 - amount)) == 32'd0)
        begin
            w_next.z  = din.z << amount;
            w_next.lz = din.lz + 5'(amount);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            w_reg <= w_next;
        end
    end

    assign dout = w_reg;

endmodule

// File: rtl/core/bmg_log_cell.sv
// one squaring step of the log2 fraction
module bmg_log_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  bmg_pkg::front_t din,
    output bmg_pkg::front_t dout
);
    import bmg_pkg::*;

    front_t      w_reg;
    front_t      w_next;
    logic [63:0] prod;
    logic [32:0] sq;

    always_comb
    begin
        prod   = 64'(din.z) * 64'(din.z);
        sq     = prod[63:31];
        w_next = din;
        if (sq[32])
        begin
            w_next.z = sq[32:1];
            w_next.f = {din.f[28:0], 1'b1};
        end
        else
        begin
            w_next.z = sq[31:0];
            w_next.f = {din.f[28:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            w_reg <= w_next;
        end
    end

    assign dout = w_reg;

endmodule

// File: rtl/core/bmg_root_cell.sv
// one digit of the integer square root
module bmg_root_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic [4:0]     step,
    input  bmg_pkg::root_t din,
    output bmg_pkg::root_t dout
);
    import bmg_pkg::*;

    root_t       w_reg;
    root_t       w_next;
    logic [5:0]  pos;
    logic [63:0] bit_val;
    logic [63:0] trial;

    always_comb
    begin
        pos     = 6'd62 - {step, 1'b0};
        bit_val = 64'd1 << pos;
        trial   = din.res + bit_val;
        w_next  = din;
        if (din.v >= trial)
        begin
            w_next.v   = din.v - trial;
            w_next.res = (din.res >> 1) + bit_val;
        end
        else
        begin
            w_next.res = din.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            w_reg <= w_next;
        end
    end

    assign dout = w_reg;

endmodule

// File: rtl/core/bmg_horner_cell.sv
// one horner step of the sine and cosine series, three stages deep
module bmg_horner_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic [2:0]     step,
    input  bmg_pkg::trig_t din,
    output bmg_pkg::trig_t dout
);
    import bmg_pkg::*;

    trig_t       w1_reg;
    trig_t       w1_next;
    trig_t       w2_reg;
    trig_t       w2_next;
    trig_t       w3_reg;
    trig_t       w3_next;
    logic [31:0] as1_reg;
    logic [31:0] as1_next;
    logic [31:0] ac1_reg;
    logic [31:0] ac1_next;
    logic [31:0] as2_reg;
    logic [31:0] as2_next;
    logic [31:0] ac2_reg;
    logic [31:0] ac2_next;
    logic [31:0] qs2_reg;
    logic [31:0] qs2_next;
    logic [31:0] qc2_reg;
    logic [31:0] qc2_next;
    logic [2:0]  idx;
    logic [63:0] ps1;
    logic [63:0] pc1;
    logic [63:0] ps2;
    logic [63:0] pc2;
    logic [31:0] rem_s;
    logic [31:0] rem_c;
    logic [31:0] qs;
    logic [31:0] qc;

    assign idx = 3'd5 - step;

    // product with the running term
    always_comb
    begin
        ps1      = 64'(din.x2) * 64'(din.hs[31:0]);
        pc1      = 64'(din.x2) * 64'(din.hc[31:0]);
        w1_next  = din;
        as1_next = din.hs[32] ? din.x2 : ps1[63:32];
        ac1_next = din.hc[32] ? din.x2 : pc1[63:32];
    end

    // reciprocal estimate of the quotient
    always_comb
    begin
        ps2      = 64'(as1_reg) * 64'(SIN_RECIP[idx]);
        pc2      = 64'(ac1_reg) * 64'(COS_RECIP[idx]);
        w2_next  = w1_reg;
        as2_next = as1_reg;
        ac2_next = ac1_reg;
        qs2_next = ps2[63:32];
        qc2_next = pc2[63:32];
    end

    // one correction step, then the new term
    always_comb
    begin
        rem_s      = as2_reg - 32'(qs2_reg * 32'(SIN_DEN[idx]));
        rem_c      = ac2_reg - 32'(qc2_reg * 32'(COS_DEN[idx]));
        qs         = qs2_reg + 32'(rem_s >= 32'(SIN_DEN[idx]));
        qc         = qc2_reg + 32'(rem_c >= 32'(COS_DEN[idx]));
        w3_next    = w2_reg;
        w3_next.hs = ONE_Q32 - 33'(qs);
        w3_next.hc = ONE_Q32 - 33'(qc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_reg.valid <= 1'b0;
            w2_reg.valid <= 1'b0;
            w3_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            w1_reg  <= w1_next;
            as1_reg <= as1_next;
            ac1_reg <= ac1_next;
            w2_reg  <= w2_next;
            as2_reg <= as2_next;
            ac2_reg <= ac2_next;
            qs2_reg <= qs2_next;
            qc2_reg <= qc2_next;
            w3_reg  <= w3_next;
        end
    end

    assign dout = w3_reg;

endmodule

// File: rtl/core/bmg_out_buf.sv
// output register with a skid stage between the pipeline and the master port
module bmg_out_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  bmg_pkg::res_t din,
    output logic          ready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output bmg_pkg::res_t dout
);
    import bmg_pkg::*;

    res_t main_reg;
    res_t main_next;
    res_t skid_reg;
    res_t skid_next;

    always_comb
    begin
        main_next = main_reg;
        skid_next = skid_reg;
        if (skid_reg.valid)
        begin
            if (m_tready)
            begin
                main_next       = skid_reg;
                skid_next.valid = 1'b0;
            end
        end
        else if (din.valid)
        begin
            if (!main_reg.valid || m_tready)
            begin
                main_next = din;
            end
            else
            begin
                skid_next = din;
            end
        end
        else if (m_tready)
        begin
            main_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_reg.valid <= 1'b0;
            skid_reg.valid <= 1'b0;
        end
        else
        begin
            main_reg <= main_next;
            skid_reg <= skid_next;
        end
    end

    assign ready    = !skid_reg.valid;
    assign m_tvalid = main_reg.valid;
    assign dout     = main_reg;

`ifndef SYNTH
    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_reg.valid |-> main_reg.valid)
        else $error("skid word held without an output word");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        main_reg.valid && !m_tready && !skid_reg.valid && din.valid |=> skid_reg.valid)
        else $error("stalled word not caught by the skid stage");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_reg.valid && m_tready |=> !skid_reg.valid && main_reg == $past(skid_reg))
        else $error("skid word not moved to the output");
`endif

endmodule

// File: rtl/core/box_muller_gaussian.sv
// box-muller gaussian source: two uniforms in, two saturated normal samples out
//
// slave channel s_*: one word carries uniform_radius and uniform_angle as unsigned
// q0.32 fractions; s_tlast carries the last-pair flag of the sample buffer
// master channel m_*: one word carries normal_sine and normal_cosine as signed
// q3.28 values; m_tlast repeats the flag of the matching input word
// a zero radius is taken as one lsb, so the logarithm stays finite
// throughput: one word per cycle while the skid stage is empty; the chain holds otherwise
// the chain from acceptance to m_tvalid is the input register, 5 normalise cells,
// 30 log squaring cells, 2 square stages, 32 root cells, 2 angle stages,
// 6 horner cells of 3 stages, 2 product stages and the output register
// reset clears every valid bit; the block holds no other state
// a stalled receiver fills the skid stage, then s_tready drops and the whole chain
// holds in place until the output word is taken
module box_muller_gaussian (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,  // uniform_radius, uniform_angle
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bmg_pkg::TDATA_W-1:0] m_tdata,  // normal_sine, normal_cosine
    output logic                        m_tlast
);
    import bmg_pkg::*;

    logic        en;
    front_t      in_reg;
    front_t      in_next;
    front_t      nf [6];
    front_t      lg [31];
    sq1_t        c1_reg;
    sq1_t        c1_next;
    root_t       c2_reg;
    root_t       c2_next;
    root_t       rt [33];
    trig_t       e1_reg;
    trig_t       e1_next;
    trig_t       e2_reg;
    trig_t       e2_next;
    trig_t       hw [7];
    fin_t        f1_reg;
    fin_t        f1_next;
    prod_t       f2_reg;
    prod_t       f2_next;
    res_t        res_word;
    res_t        out_word;
    logic [31:0] um;
    logic [5:0]  int_part;
    logic [29:0] frac_part;
    logic [38:0] square;
    logic [29:0] r30;
    logic [62:0] rp;
    logic [63:0] xsq;
    logic [63:0] sp;
    logic [2:0]  oct_p1;
    logic [2:0]  oct_p2;
    logic [32:0] ts;
    logic [32:0] tc;

    function automatic logic [SAMPLE_BITS-1:0] scale_out(input logic [63:0] prod,
                                                         input logic neg);
        logic [64:0]            sum;
        logic [SAMPLE_BITS-1:0] mag;
        sum = {1'b0, prod} + (65'd1 << (ROUND_SH - 1));
        mag = sum[64:ROUND_SH];
        if (neg)
        begin
            if (mag > SAT_NEG)
            begin
                mag = SAT_NEG;
            end
            mag = -mag;
        end
        else if (mag > SAT_POS)
        begin
            mag = SAT_POS;
        end
        return mag;
    endfunction

    assign s_tready = en;

    // input stage
    always_comb
    begin
        um = s_tdata[31:0] & UMASK;
        if (um == 32'd0)
        begin
            um = 32'd1;
        end
        in_next.valid = s_tvalid;
        in_next.last  = s_tlast;
        in_next.angle = (s_tdata[63:32] & UMASK) << (32 - UNIFORM_BITS);
        in_next.z     = um << (32 - UNIFORM_BITS);
        in_next.lz    = 5'd0;
        in_next.f     = 30'd0;
    end

    assign nf[0] = in_reg;

    for (genvar k = 0; k < 5; k++)
    begin : g_norm
        bmg_norm_cell u_norm (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .level (3'(4 - k)),
            .din   (nf[k]),
            .dout  (nf[k+1])
        );
    end

    assign lg[0] = nf[5];

    for (genvar k = 0; k < 30; k++)
    begin : g_log
        bmg_log_cell u_log (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (lg[k]),
            .dout  (lg[k+1])
        );
    end

    // -log2 split into integer and fraction, each scaled by ln2
    always_comb
    begin
        frac_part     = 30'd0 - lg[30].f;
        int_part      = (lg[30].f == 30'd0) ? 6'(lg[30].lz) + 6'd1 : 6'(lg[30].lz);
        c1_next.valid = lg[30].valid;
        c1_next.last  = lg[30].last;
        c1_next.angle = lg[30].angle;
        c1_next.t1    = 38'(int_part) * 38'(LN2_Q32);
        c1_next.t2    = 62'(frac_part) * 62'(LN2_Q32);
    end

    always_comb
    begin
        square        = {c1_reg.t1, 1'b0} + 39'(c1_reg.t2 >> 29);
        c2_next.valid = c1_reg.valid;
        c2_next.last  = c1_reg.last;
        c2_next.angle = c1_reg.angle;
        c2_next.v     = 64'(square) << 26;
        c2_next.res   = 64'd0;
    end

    assign rt[0] = c2_reg;

    for (genvar k = 0; k < 32; k++)
    begin : g_root
        bmg_root_cell u_root (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .step  (5'(k)),
            .din   (rt[k]),
            .dout  (rt[k+1])
        );
    end

    // octant reduction and angle in radians
    always_comb
    begin
        e1_next.valid = rt[32].valid;
        e1_next.last  = rt[32].last;
        e1_next.oct   = rt[32].angle[31:29];
        e1_next.amp   = rt[32].res[31:0];
        if (rt[32].angle[29])
        begin
            r30 = 30'h2000_0000 - {1'b0, rt[32].angle[28:0]};
        end
        else
        begin
            r30 = {1'b0, rt[32].angle[28:0]};
        end
        rp         = 63'(r30[28:0]) * 63'(PI_Q32);
        e1_next.xr = r30[29] ? PI_QUARTER : rp[62:31];
        e1_next.x2 = 32'd0;
        e1_next.hs = ONE_Q32;
        e1_next.hc = ONE_Q32;
    end

    always_comb
    begin
        xsq        = 64'(e1_reg.xr) * 64'(e1_reg.xr);
        e2_next    = e1_reg;
        e2_next.x2 = xsq[63:32];
    end

    assign hw[0] = e2_reg;

    for (genvar k = 0; k < 6; k++)
    begin : g_horner
        bmg_horner_cell u_horner (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .step  (3'(k)),
            .din   (hw[k]),
            .dout  (hw[k+1])
        );
    end

    always_comb
    begin
        sp            = 64'(hw[6].xr) * 64'(hw[6].hs[31:0]);
        f1_next.valid = hw[6].valid;
        f1_next.last  = hw[6].last;
        f1_next.oct   = hw[6].oct;
        f1_next.amp   = hw[6].amp;
        f1_next.s     = hw[6].hs[32] ? {1'b0, hw[6].xr} : {1'b0, sp[63:32]};
        f1_next.c     = hw[6].hc;
    end

    // octant symmetry and amplitude products
    always_comb
    begin
        oct_p1 = f1_reg.oct + 3'd1;
        oct_p2 = f1_reg.oct + 3'd2;
        if (oct_p1[1])
        begin
            ts = f1_reg.c;
            tc = f1_reg.s;
        end
        else
        begin
            ts = f1_reg.s;
            tc = f1_reg.c;
        end
        f2_next.valid = f1_reg.valid;
        f2_next.last  = f1_reg.last;
        f2_next.neg_s = f1_reg.oct[2];
        f2_next.neg_c = oct_p2[2];
        f2_next.ps    = ts[32] ? {f1_reg.amp, 32'd0} : 64'(f1_reg.amp) * 64'(ts[31:0]);
        f2_next.pc    = tc[32] ? {f1_reg.amp, 32'd0} : 64'(f1_reg.amp) * 64'(tc[31:0]);
    end

    always_comb
    begin
        res_word.valid  = f2_reg.valid;
        res_word.last   = f2_reg.last;
        res_word.sine   = scale_out(f2_reg.ps, f2_reg.neg_s);
        res_word.cosine = scale_out(f2_reg.pc, f2_reg.neg_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg.valid <= 1'b0;
            c1_reg.valid <= 1'b0;
            c2_reg.valid <= 1'b0;
            e1_reg.valid <= 1'b0;
            e2_reg.valid <= 1'b0;
            f1_reg.valid <= 1'b0;
            f2_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            in_reg <= in_next;
            c1_reg <= c1_next;
            c2_reg <= c2_next;
            e1_reg <= e1_next;
            e2_reg <= e2_next;
            f1_reg <= f1_next;
            f2_reg <= f2_next;
        end
    end

    bmg_out_buf u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .din      (res_word),
        .ready    (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dout     (out_word)
    );

    assign m_tdata = TDATA_W'({out_word.cosine, out_word.sine});
    assign m_tlast = out_word.last;

endmodule
